### rtl/sstf_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// SSTF scheduler package
// Sizes, the search candidate type and the control bundle that the
// scheduler hands to its row of request cells.
// ---------------------------------------------------------------------------
package sstf_pkg;

  localparam int MAX_REQUESTS = 64;
  localparam int TRACK_BITS   = 16;

  // The first request of a batch is the head position and lives outside the row.
  localparam int NCELL     = MAX_REQUESTS - 1;
  localparam int IDX_BITS  = (NCELL > 1) ? $clog2(NCELL) : 1;
  localparam int CNT_BITS  = $clog2(NCELL + 1);
  localparam int SUM_BITS  = 22;
  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

  typedef struct packed {
    logic                  valid;
    logic [TRACK_BITS-1:0] track;
    logic [TRACK_BITS-1:0] seek;
    logic [IDX_BITS-1:0]   idx;
  } cand_t;

  typedef struct packed {
    logic                  load;
    logic [TRACK_BITS-1:0] load_track;
    logic                  clear_en;
    logic [IDX_BITS-1:0]   clear_idx;
    logic [TRACK_BITS-1:0] head;
  } chain_ctrl_t;

  function automatic logic [TRACK_BITS-1:0] abs_diff(
    input logic [TRACK_BITS-1:0] a,
    input logic [TRACK_BITS-1:0] b
  );
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage
`default_nettype wire

### rtl/sstf_request_scheduler.sv
`default_nettype none
// ---------------------------------------------------------------------------
// SSTF request scheduler
// Collects a batch of track requests and serves them nearest-first.
// ---------------------------------------------------------------------------
// Requests load at one beat per clock. The first beat of a batch is the
// starting head position; the beat with last_request set closes the batch and
// the block then takes no requests until the final result of the batch is
// in the output register. Service runs as a search through the row of 63
// request cells: for each served request the candidate crosses the row and
// is then captured, so a batch of n requests (n up to 64) yields n-1 results.
// A batch of one request gives its single zero-distance result from S_SINGLE.
// Results wait in an output register, so a stalled result delays the search.
// ---------------------------------------------------------------------------
module sstf_request_scheduler (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_stall,
  input  wire logic [sstf_pkg::TRACK_BITS-1:0] track,
  input  wire logic                            last_request,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_stall,
  output logic      [sstf_pkg::TRACK_BITS-1:0] served_track,
  output logic      [sstf_pkg::TRACK_BITS-1:0] seek_distance,
  output logic      [sstf_pkg::SUM_BITS-1:0]   total_distance,
  output logic                                 overflow,
  output logic                                 last
);
  import sstf_pkg::*;

  typedef enum logic [1:0] {S_LOAD, S_SEARCH, S_SINGLE} state_t;

  state_t                state;
  logic                  have_head;
  logic [TRACK_BITS-1:0] head;
  logic [CNT_BITS-1:0]   chain_cnt;
  logic [CNT_BITS-1:0]   remaining;
  logic [CNT_BITS-1:0]   wait_cnt;
  logic                  dropped;
  logic [SUM_BITS-1:0]   sum;

  chain_ctrl_t           ctrl;
  cand_t                 cand_last;
  logic                  req_take;
  logic                  out_free;
  logic                  serve;
  logic                  rsp_load;
  logic [SUM_BITS:0]     sum_wide;
  logic [SUM_BITS-1:0]   sum_next;

  sstf_cell_row u_row (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cand_last (cand_last)
  );

  always_comb begin
    req_stall = (state != S_LOAD);
    req_take  = req_valid && !req_stall;
    out_free  = !rsp_valid || !rsp_stall;
    serve     = (state == S_SEARCH) && (wait_cnt == '0) && out_free;
    rsp_load  = serve || ((state == S_SINGLE) && out_free);
    sum_wide  = {1'b0, sum} + (SUM_BITS+1)'(cand_last.seek);
    sum_next  = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_BITS-1:0];

    ctrl.load       = req_take && have_head && (chain_cnt != CNT_BITS'(NCELL));
    ctrl.load_track = track;
    ctrl.clear_en   = serve;
    ctrl.clear_idx  = cand_last.idx;
    ctrl.head       = head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      have_head <= 1'b0;
      chain_cnt <= '0;
      remaining <= '0;
      wait_cnt  <= '0;
      dropped   <= 1'b0;
      sum       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (req_take) begin
            if (!have_head) begin
              head      <= track;
              have_head <= 1'b1;
              if (last_request) begin
                state <= S_SINGLE;
              end
            end else begin
              if (ctrl.load) begin
                chain_cnt <= chain_cnt + 1'b1;
              end else begin
                dropped <= 1'b1;
              end
              if (last_request) begin
                state     <= S_SEARCH;
                wait_cnt  <= CNT_BITS'(NCELL);
                sum       <= '0;
                remaining <= ctrl.load ? chain_cnt + 1'b1 : chain_cnt;
              end
            end
          end
        end
        S_SINGLE: begin
          if (out_free) begin
            rsp_valid      <= 1'b1;
            served_track   <= head;
            seek_distance  <= '0;
            total_distance <= '0;
            overflow       <= dropped;
            last           <= 1'b1;
            have_head      <= 1'b0;
            chain_cnt      <= '0;
            dropped        <= 1'b0;
            state          <= S_LOAD;
          end
        end
        S_SEARCH: begin
          if (wait_cnt != '0) begin
            wait_cnt <= wait_cnt - 1'b1;
          end else if (serve) begin
            rsp_valid      <= 1'b1;
            served_track   <= cand_last.track;
            seek_distance  <= cand_last.seek;
            total_distance <= sum_next;
            overflow       <= dropped;
            last           <= (remaining == CNT_BITS'(1));
            head           <= cand_last.track;
            sum            <= sum_next;
            remaining      <= remaining - 1'b1;
            wait_cnt       <= CNT_BITS'(NCELL);
            if (remaining == CNT_BITS'(1)) begin
              have_head <= 1'b0;
              chain_cnt <= '0;
              dropped   <= 1'b0;
              state     <= S_LOAD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // A search always has at least one request left to serve.
  a_search_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (remaining != '0))
    else $error("search running with no pending requests");

  // Whenever a request is served, the row must have produced a winner.
  a_serve_has_winner: assert property (@(posedge clk) disable iff (rst)
    serve |-> cand_last.valid)
    else $error("serve without a valid candidate");

  // Serving the final request returns the block to loading.
  a_final_returns: assert property (@(posedge clk) disable iff (rst)
    (serve && (remaining == CNT_BITS'(1))) |=> ((state == S_LOAD) && rsp_valid && last))
    else $error("final serve did not close the batch");

  // The running total never falls below the move that it includes.
  a_total_covers_seek: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (total_distance >= SUM_BITS'(seek_distance)))
    else $error("running total below seek distance");

  // The row never holds more requests than it has cells.
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    chain_cnt <= CNT_BITS'(NCELL))
    else $error("row count beyond capacity");

endmodule
`default_nettype wire

### rtl/sstf_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// SSTF request cell
// Holds one stored request and its pending mark, and passes on the better
// of its own request and the candidate arriving from its neighbour.
// ---------------------------------------------------------------------------
module sstf_cell (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire sstf_pkg::chain_ctrl_t          ctrl,
  input  wire logic [sstf_pkg::IDX_BITS-1:0]  my_idx,
  input  wire logic [sstf_pkg::TRACK_BITS-1:0] prev_track,
  input  wire logic                           prev_pending,
  input  wire sstf_pkg::cand_t                cand_prev,
  output logic      [sstf_pkg::TRACK_BITS-1:0] track,
  output logic                                pending,
  output sstf_pkg::cand_t                     cand
);
  import sstf_pkg::*;

  logic [TRACK_BITS-1:0] own_dist;
  logic                  take_own;
  cand_t                 cand_next;

  always_comb begin
    own_dist = abs_diff(track, ctrl.head);
    // Nearer wins; on equal distance the higher track wins.
    take_own = pending && (!cand_prev.valid || (own_dist < cand_prev.seek) ||
               ((own_dist == cand_prev.seek) && (track > cand_prev.track)));
    if (take_own) begin
      cand_next.valid = 1'b1;
      cand_next.track = track;
      cand_next.seek  = own_dist;
      cand_next.idx   = my_idx;
    end else begin
      cand_next = cand_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      track <= prev_track;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= 1'b0;
      cand.valid <= 1'b0;
    end else begin
      if (ctrl.load) begin
        pending <= prev_pending;
      end else if (ctrl.clear_en && (ctrl.clear_idx == my_idx)) begin
        pending <= 1'b0;
      end
      cand.valid <= cand_next.valid;
    end
    cand.track <= cand_next.track;
    cand.seek  <= cand_next.seek;
    cand.idx   <= cand_next.idx;
  end

endmodule
`default_nettype wire

### rtl/sstf_cell_row.sv
`default_nettype none
// ---------------------------------------------------------------------------
// SSTF cell row
// A row of request cells. New requests shift in at cell zero; the search
// candidate travels from cell zero to the far end, one cell per cycle.
// ---------------------------------------------------------------------------
module sstf_cell_row (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sstf_pkg::chain_ctrl_t ctrl,
  output sstf_pkg::cand_t            cand_last
);
  import sstf_pkg::*;

  logic [TRACK_BITS-1:0] track_q   [NCELL];
  logic                  pending_q [NCELL];
  cand_t                 cand_q    [NCELL];

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic [TRACK_BITS-1:0] prev_track;
    logic                  prev_pending;
    cand_t                 cand_prev;

    if (i == 0) begin : g_first
      assign prev_track   = ctrl.load_track;
      assign prev_pending = 1'b1;
      assign cand_prev    = '0;
    end else begin : g_next
      assign prev_track   = track_q[i-1];
      assign prev_pending = pending_q[i-1];
      assign cand_prev    = cand_q[i-1];
    end

    sstf_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .my_idx       (IDX_BITS'(i)),
      .prev_track   (prev_track),
      .prev_pending (prev_pending),
      .cand_prev    (cand_prev),
      .track        (track_q[i]),
      .pending      (pending_q[i]),
      .cand         (cand_q[i])
    );
  end

  assign cand_last = cand_q[NCELL-1];

endmodule
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// SSTF request scheduler testbench
// Sends batches of track requests and checks every served request against a
// nearest-first predictor, with random idling on both channels.
// ---------------------------------------------------------------------------
module testbench;

  localparam int TB = sstf_pkg::TRACK_BITS;
  localparam int SB = sstf_pkg::SUM_BITS;
  localparam int BATCH_CAP = sstf_pkg::MAX_REQUESTS;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_ITEMS = 70;
  localparam int CALM_ITEMS = 20;

  typedef struct packed {
    logic [TB-1:0] served_track;
    logic [TB-1:0] seek_distance;
    logic [SB-1:0] total_distance;
    logic          overflow;
    logic          last;
  } seek_move_t;

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_stall;
  logic [TB-1:0] track;
  logic          last_request;
  logic          rsp_valid;
  logic          rsp_stall;
  logic [TB-1:0] served_track;
  logic [TB-1:0] seek_distance;
  logic [SB-1:0] total_distance;
  logic          overflow;
  logic          last;

  // Predictor state for the batch being collected.
  logic [TB-1:0] batch_tracks [BATCH_CAP];
  bit            batch_served [BATCH_CAP];
  int unsigned   batch_size;
  logic [TB-1:0] head_track;
  logic [SB-1:0] seek_total;
  bit            batch_dropped;

  seek_move_t    expected_moves[$];
  int unsigned   error_count;
  int unsigned   items_sent;
  int unsigned   quiet_cycles;
  int unsigned   rsp_hold;
  bit            calm;

  sstf_request_scheduler dut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .track          (track),
    .last_request   (last_request),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .served_track   (served_track),
    .seek_distance  (seek_distance),
    .total_distance (total_distance),
    .overflow       (overflow),
    .last           (last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [TB-1:0] track_gap(input logic [TB-1:0] a, input logic [TB-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  task automatic clear_batch;
    for (int i = 0; i < BATCH_CAP; i++) batch_served[i] = 1'b0;
    batch_size    = 0;
    seek_total    = '0;
    batch_dropped = 1'b0;
  endtask

  // Stores one request and, when it closes the batch, queues every move.
  task automatic predict_request(input logic [TB-1:0] trk, input logic fin);
    int unsigned best;
    bit          found;
    logic [TB-1:0] best_d;
    logic [TB-1:0] d;
    logic [SB:0]   acc;
    seek_move_t    move;
    if (batch_size < BATCH_CAP) begin
      batch_tracks[batch_size] = trk;
      batch_served[batch_size] = 1'b0;
      batch_size++;
    end else begin
      batch_dropped = 1'b1;
    end
    if (!fin) return;
    head_track      = batch_tracks[0];
    batch_served[0] = 1'b1;
    seek_total      = '0;
    if (batch_size <= 1) begin
      move = '{head_track, '0, '0, batch_dropped, 1'b1};
      expected_moves.insert(expected_moves.size(), move);
    end else begin
      for (int k = 1; k < batch_size; k++) begin
        best   = 0;
        found  = 1'b0;
        best_d = '0;
        for (int i = 1; i < batch_size; i++) begin
          if (batch_served[i]) continue;
          d = track_gap(batch_tracks[i], head_track);
          // Equal distance goes towards the higher track.
          if (!found || d < best_d ||
              (d == best_d && batch_tracks[i] > batch_tracks[best])) begin
            best   = i;
            best_d = d;
            found  = 1'b1;
          end
        end
        batch_served[best] = 1'b1;
        acc = {1'b0, seek_total} + best_d;
        seek_total = (acc > sstf_pkg::SUM_MAX) ? sstf_pkg::SUM_MAX : acc[SB-1:0];
        head_track = batch_tracks[best];
        move = '{head_track, best_d, seek_total, batch_dropped, (k + 1 == batch_size)};
        expected_moves.insert(expected_moves.size(), move);
      end
    end
    clear_batch();
  endtask

  // One request beat; the payload holds until the block accepts it.
  task automatic send_request(input logic [TB-1:0] trk, input logic fin);
    req_valid    <= 1'b1;
    track        <= trk;
    last_request <= fin;
    do @(posedge clk); while (req_stall);
    predict_request(trk, fin);
    items_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic wait_for_moves;
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_moves.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    seek_move_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_moves.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual track %0d", $time,
                 served_track);
        error_count++;
      end else begin
        want = expected_moves.pop_front();
        check_field("served_track", want.served_track, served_track);
        check_field("seek_distance", want.seek_distance, seek_distance);
        check_field("total_distance", want.total_distance, total_distance);
        check_field("overflow", want.overflow, overflow);
        check_field("last", want.last, last);
      end
    end
  end

  // The receiver stalls in bursts of random length.
  always @(posedge clk) begin
    if (rst || calm) begin
      rsp_stall <= 1'b0;
      rsp_hold  <= 0;
    end else if (rsp_hold > 1) begin
      rsp_hold <= rsp_hold - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      rsp_stall <= 1'b1;
      rsp_hold  <= $urandom_range(1, 7);
    end else begin
      rsp_stall <= 1'b0;
      rsp_hold  <= 0;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_single_request;
    send_request('0, 1'b1);
    send_request('1, 1'b1);
    wait_for_moves();
  endtask

  task automatic test_extreme_tracks;
    send_request(16'd0, 1'b0);
    send_request(16'hFFFF, 1'b1);
    send_request(16'hFFFF, 1'b0);
    send_request(16'd0, 1'b0);
    send_request(16'h8000, 1'b1);
    wait_for_moves();
  endtask

  task automatic test_equal_distance;
    send_request(16'd1000, 1'b0);
    send_request(16'd990, 1'b0);
    send_request(16'd1010, 1'b0);
    send_request(16'd980, 1'b0);
    send_request(16'd1020, 1'b1);
    send_request(16'd8, 1'b0);
    send_request(16'd4, 1'b0);
    send_request(16'd12, 1'b1);
    wait_for_moves();
  endtask

  task automatic test_duplicates;
    send_request(16'd5, 1'b0);
    send_request(16'd5, 1'b0);
    send_request(16'd7, 1'b0);
    send_request(16'd5, 1'b0);
    send_request(16'd3, 1'b1);
    wait_for_moves();
  endtask

  // A batch that just fits, then one whose closing beat is itself dropped.
  task automatic test_batch_full;
    for (int i = 0; i < BATCH_CAP; i++) send_request(TB'($urandom), i == BATCH_CAP - 1);
    for (int i = 0; i < BATCH_CAP + 2; i++) send_request(TB'($urandom), i == BATCH_CAP + 1);
    wait_for_moves();
  endtask

  task automatic test_random_batches;
    int unsigned   size;
    int unsigned   style;
    logic [TB-1:0] base;
    logic [TB-1:0] trk;
    int unsigned   start;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if (items_sent - start >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      case ($urandom_range(0, 9))
        0:       size = 1;
        1:       size = $urandom_range(9, 24);
        default: size = $urandom_range(2, 8);
      endcase
      style = $urandom_range(0, 2);
      base  = TB'($urandom);
      for (int i = 0; i < size; i++) begin
        case (style)
          0: trk = TB'($urandom);
          // Tight clusters give many duplicates and equal distances.
          1: trk = base + TB'($urandom_range(0, 8));
          default: trk = ($urandom_range(0, 2) == 0) ? TB'($urandom) :
                         (($urandom_range(0, 1) == 0) ? '0 : '1);
        endcase
        send_request(trk, i == size - 1);
      end
      if (!calm && $urandom_range(0, 7) == 0) wait_for_moves();
    end
  endtask

  initial begin
    rst          <= 1'b1;
    req_valid    <= 1'b0;
    track        <= '0;
    last_request <= 1'b0;
    rsp_stall    <= 1'b0;
    calm          = 1'b0;
    error_count   = 0;
    items_sent    = 0;
    clear_batch();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_request();
    test_extreme_tracks();
    test_equal_distance();
    test_duplicates();
    test_batch_full();
    test_random_batches();

    wait_for_moves();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_moves.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0", $time,
               expected_moves.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
